// ----- rtl/core/sov_pkg.sv -----
package sov_pkg;

  localparam int TILE_DEPTH = 16384;
  localparam int TILE_AW    = $clog2(TILE_DEPTH);
  localparam int TILE_TW    = 17;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_BAD_REGION  = 2'd1;
  localparam logic [1:0] STAT_BAD_OVERLAY = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX   = 2'd3;

  localparam logic [2:0] REG_OFFSET_X       = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y       = 3'd1;
  localparam logic [2:0] REG_REGION_WIDTH   = 3'd2;
  localparam logic [2:0] REG_REGION_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_OVERLAY_WIDTH  = 3'd4;
  localparam logic [2:0] REG_OVERLAY_HEIGHT = 3'd5;
  localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd6;
  localparam logic [2:0] REG_PAINT_MODE     = 3'd7;

  localparam logic FMT_RGBA2222 = 1'b0;
  localparam logic FMT_RGBA8888 = 1'b1;
  localparam logic MODE_XOR     = 1'b1;

  localparam logic [7:0] LEVEL_WEIGHT = 8'd85;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] pixel_index;
    logic [7:0]  load_red;
    logic [7:0]  load_green;
    logic [7:0]  load_blue;
    logic [31:0] source_pixel;
    logic        first_pixel;
  } item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       wrote_pixel;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic signed [12:0] offset_x;
    logic signed [12:0] offset_y;
    logic [7:0]         region_width;
    logic [7:0]         region_height;
    logic [11:0]        overlay_width;
    logic [11:0]        overlay_height;
    logic               pixel_format;
    logic               paint_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] pixel_index;
    logic [23:0] load_rgb;
    logic [1:0]  pre_status;
    logic        draw;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [5:0]  color;
    logic        xor_en;
  } job_t;

  function automatic logic [5:0] pack222(input logic [23:0] rgb);
    return {rgb[23:22], rgb[15:14], rgb[7:6]};
  endfunction

  function automatic logic [23:0] expand222(input logic [5:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = 8'({6'd0, c[1:0]} * LEVEL_WEIGHT);
    g = 8'({6'd0, c[3:2]} * LEVEL_WEIGHT);
    b = 8'({6'd0, c[5:4]} * LEVEL_WEIGHT);
    return {b, g, r};
  endfunction

endpackage

// ----- rtl/core/sov_ram.sv -----
module sov_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/core/sov_cfg.sv -----
module sov_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [12:0]   cfg_data,
  output sov_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sov_pkg::REG_OFFSET_X:       cfg.offset_x       <= $signed(cfg_data);
        sov_pkg::REG_OFFSET_Y:       cfg.offset_y       <= $signed(cfg_data);
        sov_pkg::REG_REGION_WIDTH:   cfg.region_width   <= cfg_data[7:0];
        sov_pkg::REG_REGION_HEIGHT:  cfg.region_height  <= cfg_data[7:0];
        sov_pkg::REG_OVERLAY_WIDTH:  cfg.overlay_width  <= cfg_data[11:0];
        sov_pkg::REG_OVERLAY_HEIGHT: cfg.overlay_height <= cfg_data[11:0];
        sov_pkg::REG_PIXEL_FORMAT:   cfg.pixel_format   <= cfg_data[0];
        sov_pkg::REG_PAINT_MODE:     cfg.paint_mode     <= cfg_data[0];
      endcase
    end
  end

endmodule

// ----- rtl/core/sov_raster.sv -----
module sov_raster (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  sov_pkg::item_t item,
  input  sov_pkg::cfg_t  cfg,
  output sov_pkg::job_t  job
);

  logic [11:0]        col;
  logic [11:0]        row;
  logic [11:0]        col_next;
  logic [11:0]        row_next;
  logic [11:0]        col_eff;
  logic [11:0]        row_eff;
  logic [12:0]        col_inc;
  logic               reg_bad;
  logic               ovl_bad;
  logic               row_in;
  logic signed [13:0] dx;
  logic signed [13:0] dy;
  logic               in_x;
  logic               in_y;
  logic               visible;
  logic [5:0]         color;
  logic               opaque;
  logic [1:0]         pre_status;

  always_comb begin
    col_eff = item.first_pixel ? 12'd0 : col;
    row_eff = item.first_pixel ? 12'd0 : row;
    col_inc = {1'b0, col_eff} + 13'd1;
    reg_bad = (cfg.region_width == 8'd0) || (cfg.region_height == 8'd0);
    ovl_bad = (cfg.overlay_width == 12'd0) || (cfg.overlay_height == 12'd0);
    row_in  = row_eff < cfg.overlay_height;
    dx      = $signed({cfg.offset_x[12], cfg.offset_x}) + $signed({2'b00, col_eff});
    dy      = $signed({cfg.offset_y[12], cfg.offset_y}) + $signed({2'b00, row_eff});
    in_x    = !dx[13] && (dx[12:0] < {5'd0, cfg.region_width});
    in_y    = !dy[13] && (dy[12:0] < {5'd0, cfg.region_height});
    visible = row_in && (col_eff < cfg.overlay_width) && in_x && in_y;
    if (cfg.pixel_format == sov_pkg::FMT_RGBA8888) begin
      color  = sov_pkg::pack222(item.source_pixel[23:0]);
      opaque = item.source_pixel[31:24] != 8'd0;
    end else begin
      color  = item.source_pixel[5:0];
      opaque = item.source_pixel[7:6] != 2'd0;
    end
    priority if (reg_bad) begin
      pre_status = sov_pkg::STAT_BAD_REGION;
    end else if (ovl_bad) begin
      pre_status = sov_pkg::STAT_BAD_OVERLAY;
    end else begin
      pre_status = sov_pkg::STAT_OK;
    end
    col_next = col_eff;
    row_next = row_eff;
    if (!reg_bad && !ovl_bad && row_in) begin
      if (col_inc >= {1'b0, cfg.overlay_width}) begin
        col_next = '0;
        row_next = row_eff + 12'd1;
      end else begin
        col_next = col_inc[11:0];
      end
    end
  end

  // advance raster position on overlay beats only
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take && item.op == sov_pkg::OP_PIXEL) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job.op          <= item.op;
      job.pixel_index <= item.pixel_index;
      job.load_rgb    <= {item.load_blue, item.load_green, item.load_red};
      job.pre_status  <= pre_status;
      job.draw        <= visible && opaque;
      job.dx          <= dx[7:0];
      job.dy          <= dy[7:0];
      job.color       <= color;
      job.xor_en      <= (cfg.pixel_format == sov_pkg::FMT_RGBA2222) &&
                         (cfg.paint_mode == sov_pkg::MODE_XOR);
    end
  end

endmodule

// ----- rtl/core/clipped_sprite_overlay_blit.sv -----
// Each accepted input beat passes through the accept, tile store address and read, and write
// back states; write back registers its result beat and waits while the output stalls.
// The tile store is a single-port RAM with a registered read, so each item finishes
// its read-modify-write before the next is taken.
// Reset: synchronous; clears configuration, raster position and control. The tile store
// is not cleared.
module clipped_sprite_overlay_blit (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  sov_pkg::item_t   pix_data,
  output logic             res_valid,
  input  logic             res_stall,
  output sov_pkg::result_t res_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [12:0]      cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  sov_pkg::cfg_t                 cfg;
  sov_pkg::job_t                 job;
  logic                          take;
  logic                          finish;
  logic [sov_pkg::TILE_TW-1:0]   tile_pos;
  logic                          tile_ok;
  logic                          idx_ok;
  logic [sov_pkg::TILE_AW-1:0]   tile_addr;
  logic                          tile_wr_ok;
  logic                          mem_en;
  logic                          mem_we;
  logic [sov_pkg::TILE_AW-1:0]   mem_addr;
  logic [23:0]                   mem_wdata;
  logic [23:0]                   mem_rdata;
  logic [5:0]                    paint;
  logic [23:0]                   paint_rgb;
  sov_pkg::result_t              result;

  sov_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sov_raster u_raster (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (pix_data),
    .cfg  (cfg),
    .job  (job)
  );

  sov_ram #(
    .WIDTH (24),
    .DEPTH (sov_pkg::TILE_DEPTH)
  ) u_tile (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign pix_stall = rst || (state != ST_IDLE);
  assign take      = pix_valid && !pix_stall;
  assign finish    = (state == ST_DATA) && (!res_valid || !res_stall);

  assign tile_pos = sov_pkg::TILE_TW'(job.dy) * sov_pkg::TILE_TW'(cfg.region_width) +
                    sov_pkg::TILE_TW'(job.dx);
  assign tile_ok  = tile_pos < sov_pkg::TILE_TW'(sov_pkg::TILE_DEPTH);
  assign idx_ok   = sov_pkg::TILE_TW'(job.pixel_index) <
                    sov_pkg::TILE_TW'(sov_pkg::TILE_DEPTH);

  assign paint     = job.xor_en ? (job.color ^ sov_pkg::pack222(mem_rdata)) : job.color;
  assign paint_rgb = sov_pkg::expand222(paint);

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = tile_addr;
    mem_wdata = paint_rgb;
    if (state == ST_ADDR) begin
      mem_en = 1'b1;
      if (job.op == sov_pkg::OP_PIXEL) begin
        mem_addr = sov_pkg::TILE_AW'(tile_pos);
      end else begin
        mem_addr  = sov_pkg::TILE_AW'(job.pixel_index);
        mem_we    = (job.op == sov_pkg::OP_LOAD) && idx_ok;
        mem_wdata = job.load_rgb;
      end
    end else if (finish && tile_wr_ok) begin
      mem_en = 1'b1;
      mem_we = 1'b1;
    end
  end

  always_comb begin
    result = '0;
    unique case (job.op)
      sov_pkg::OP_LOAD: begin
        if (idx_ok) begin
          {result.out_blue, result.out_green, result.out_red} = job.load_rgb;
        end else begin
          result.status = sov_pkg::STAT_BAD_INDEX;
        end
      end
      sov_pkg::OP_READ: begin
        if (idx_ok) begin
          {result.out_blue, result.out_green, result.out_red} = mem_rdata;
        end else begin
          result.status = sov_pkg::STAT_BAD_INDEX;
        end
      end
      sov_pkg::OP_PIXEL: begin
        priority if (job.pre_status != sov_pkg::STAT_OK) begin
          result.status = job.pre_status;
        end else if (job.draw && !tile_wr_ok) begin
          result.status = sov_pkg::STAT_BAD_INDEX;
        end else if (tile_wr_ok) begin
          {result.out_blue, result.out_green, result.out_red} = paint_rgb;
          result.wrote_pixel = 1'b1;
        end else begin
          result = '0;
        end
      end
      default: result = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (take) state_next = ST_ADDR;
      ST_ADDR: state_next = ST_DATA;
      ST_DATA: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tile_wr_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ADDR) begin
        tile_wr_ok <= (job.op == sov_pkg::OP_PIXEL) &&
                      (job.pre_status == sov_pkg::STAT_OK) && job.draw && tile_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADDR) begin
      tile_addr <= sov_pkg::TILE_AW'(tile_pos);
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_data <= result;
    end
  end

  a_take_from_idle: assert property (@(posedge clk) disable iff (rst)
    take |=> state == ST_ADDR)
    else $error("input beat taken outside idle");

  a_result_after_data: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_DATA)
    else $error("result beat raised without write-back step");

  a_wrote_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.wrote_pixel) |-> res_data.status == sov_pkg::STAT_OK)
    else $error("written pixel carries an error status");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state != ST_IDLE)
    else $error("tile store written while idle");

endmodule
